FILE: design/pfem_pkg.sv
`default_nettype none

package pfem_pkg;

  localparam int unsigned COUNTER_BITS_DEF = 16;

  localparam logic [31:0] DEFAULT_HZ      = 32'd25000000;
  localparam logic [15:0] DEFAULT_TIMEOUT = 16'd2500;

  // nominal/200 is done as (nominal >> 3) / 25 with a reciprocal multiply
  localparam int unsigned TOL_DIV       = 200;
  localparam int unsigned TOL_PRE_SHIFT = 3;
  localparam int unsigned TOL_W         = 25;
  localparam logic [29:0] TOL_RESIDUE   = 30'(TOL_DIV >> TOL_PRE_SHIFT);
  localparam logic [31:0] TOL_RECIP     = 32'd171798691;  // floor(2^32 / 25)

  localparam int unsigned SCALE_W   = 30;
  localparam logic [31:0] PPB_SCALE = 32'd1000000000;
  localparam logic [SCALE_W-1:0] PPB_LIMIT = SCALE_W'(5000000);
  localparam int unsigned DIV_STEPS = SCALE_W;

  typedef enum logic [1:0] {
    OP_OVERFLOW = 2'd0,
    OP_CAPTURE  = 2'd1,
    OP_STATUS   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_NOMINAL = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_RUN     = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_NO_CLOCK  = 3'd1,
    ST_NO_PULSE  = 3'd2,
    ST_SETTLING  = 3'd3,
    ST_MEASURING = 3'd4
  } status_e;

  typedef struct packed {
    logic [31:0] nominal;  // zero already replaced by the default
    logic [15:0] timeout;
    logic        run;
    logic        clear;
  } cfg_t;

  typedef struct packed {
    logic [15:0] counter_now;
    logic [31:0] now_ms;
    logic        overflow_pending;
    logic [15:0] capture_count;
  } in_data_t;

  typedef struct packed {
    logic [31:0]        last_interval;
    logic signed [23:0] error_ppb;
    logic [31:0]        seconds;
  } out_data_t;

  localparam int unsigned IN_TDATA_W  = (($bits(in_data_t) + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = (($bits(out_data_t) + 7) / 8) * 8;

endpackage

`default_nettype wire

FILE: design/pfem_cfg.sv
`default_nettype none

module pfem_cfg
  import pfem_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output cfg_t             cfg_o
);

  logic [31:0] nominal_q;
  logic [15:0] timeout_q;
  logic        run_q;
  logic        run_wr;

  assign cfg_ready_o = 1'b1;
  assign run_wr = cfg_valid_i && (reg_e'(cfg_index_i) == REG_RUN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q <= DEFAULT_HZ;
      timeout_q <= DEFAULT_TIMEOUT;
      run_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_NOMINAL: nominal_q <= cfg_data_i;
        REG_TIMEOUT: timeout_q <= cfg_data_i[15:0];
        REG_RUN:     run_q     <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    cfg_o.nominal = (nominal_q != '0) ? nominal_q : DEFAULT_HZ;
    cfg_o.timeout = timeout_q;
    cfg_o.run     = run_q;
    // writing one to run clears the measurement at the same edge
    cfg_o.clear   = run_wr && cfg_data_i[0];
  end

endmodule

`default_nettype wire

FILE: design/pfem_mul.sv
`default_nettype none

module pfem_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [63:0]      prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= 64'(a_i) * 64'(b_i);
  end

endmodule

`default_nettype wire

FILE: design/pps_frequency_error_meter_unit.sv
`default_nettype none

// PPS frequency error meter. Input ops (tuser): counter overflow, pulse capture and
// status read; only a status read returns a result. An overflow leaves the unit idle;
// a capture after the first runs S_TOL_MUL, S_TOL_FIX and S_WINDOW (the window test
// uses the shared 32x32 multiplier to form nominal/200). A status read that ends early
// (idle, no clock, no pulse, settling) goes straight to S_RESULT; a measuring read forms
// the error product m*1e9 in two passes through the shared multiplier and runs a 30-step
// restoring division through one shared 65-bit subtractor, one quotient bit a cycle.
// Errors of 100% or more skip the division. The input side is ready again as soon as
// the result sits in the output register.
module pps_frequency_error_meter_unit
  import pfem_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // capture_count, overflow_pending, now_ms, counter_now
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // op
  input  wire logic [1:0]             s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // seconds, error_ppb, last_interval
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // status
  output logic [2:0]                  m_axis_tuser_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [1:0]             cfg_index_i,
  input  wire logic [31:0]            cfg_data_i
);

  localparam int unsigned OVF_W    = (COUNTER_BITS < 32) ? 32 - COUNTER_BITS : 1;
  localparam int unsigned CC_W     = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
  localparam int unsigned HALF_IDX = (COUNTER_BITS <= 16) ? COUNTER_BITS - 1 : 0;
  localparam int unsigned N_W      = 64 + SCALE_W;
  localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_TOL_MUL, S_TOL_FIX, S_WINDOW, S_EXP_MUL, S_DIFF, S_NEGATE,
    S_RANGE, S_N_LO, S_N_HI, S_N_ADD, S_DIV_INIT, S_DIV, S_SIGN, S_RESULT
  } state_e;

  cfg_t     cfg;
  in_data_t s_data;
  state_e   state_q;

  // measurement state
  logic [OVF_W-1:0] ovf_q;
  logic [31:0]      prev_tick_q;
  logic             have_prev_q;
  logic [63:0]      sum_q;
  logic [31:0]      total_q;
  logic [31:0]      latest_q;
  logic [31:0]      last_pulse_q;
  logic [15:0]      probe_q;

  // working registers
  logic [31:0]        delta_q;
  logic [TOL_W-1:0]   tol_q;
  logic [63:0]        m_q;
  logic [63:0]        e_q;
  logic               neg_q;
  logic [N_W-1:0]     n_q;
  logic [63:0]        rem_q;
  logic [SCALE_W-1:0] quot_q;
  logic [CNT_W-1:0]   div_cnt_q;

  logic [2:0]  res_status_q;
  logic [31:0] res_seconds_q;
  logic [23:0] res_ppb_q;
  logic [31:0] res_last_q;

  logic        m_valid_q;
  out_data_t   m_data_q;
  logic [2:0]  m_user_q;

  // shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [64:0] sub_a, sub_b;
  logic [65:0] sub_diff;
  logic        borrow;

  logic             s_fire;
  logic [OVF_W-1:0] ovf_inc;
  logic [31:0]      tick;
  logic             below_half;
  logic [31:0]      elapsed;
  logic [TOL_W-1:0] q0;
  logic [29:0]      tol_rem;
  logic [31:0]      win_lo;
  logic [32:0]      win_hi;
  logic             outside;
  logic [64:0]      div_shift;
  logic [SCALE_W-1:0] q_clip;
  logic             out_free;

  pfem_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pfem_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign s_data          = in_data_t'(s_axis_tdata_i[$bits(in_data_t)-1:0]);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(m_data_q);
  assign m_axis_tuser_o  = m_user_q;

  // tick extension with the half-range rule for a pending overflow
  assign below_half = (COUNTER_BITS > 16) || !s_data.capture_count[HALF_IDX];
  assign ovf_inc    = ovf_q + OVF_W'(s_data.overflow_pending && below_half);
  assign tick       = 32'(s_data.capture_count[CC_W-1:0]) | (32'(ovf_inc) << COUNTER_BITS);
  assign elapsed    = s_data.now_ms - last_pulse_q;

  // reciprocal quotient is low by at most one
  assign q0      = prod[32 +: TOL_W];
  assign tol_rem = {1'b0, cfg.nominal[31:TOL_PRE_SHIFT]} - 30'(q0) * TOL_RESIDUE;

  assign win_lo  = cfg.nominal - 32'(tol_q);
  assign win_hi  = {1'b0, cfg.nominal} + 33'(tol_q);
  assign outside = (delta_q < win_lo) || ({1'b0, delta_q} > win_hi);

  assign div_shift = {rem_q, n_q[SCALE_W-1]};
  assign q_clip    = (quot_q > PPB_LIMIT) ? PPB_LIMIT : quot_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_TOL_MUL: begin
        mul_a = 32'(cfg.nominal[31:TOL_PRE_SHIFT]);
        mul_b = TOL_RECIP;
      end
      S_EXP_MUL: begin
        mul_a = total_q;
        mul_b = cfg.nominal;
      end
      S_N_LO: begin
        mul_a = m_q[31:0];
        mul_b = PPB_SCALE;
      end
      S_N_HI: begin
        mul_a = m_q[63:32];
        mul_b = PPB_SCALE;
      end
      default: ;
    endcase
  end

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_q)
      S_DIFF: begin
        sub_a = {1'b0, sum_q};
        sub_b = {1'b0, prod};
      end
      S_NEGATE: sub_b = {1'b0, m_q};
      S_RANGE: begin
        sub_a = {1'b0, m_q};
        sub_b = {1'b0, e_q};
      end
      S_DIV: begin
        sub_a = div_shift;
        sub_b = {1'b0, e_q};
      end
      default: ;
    endcase
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = sub_diff[65];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ovf_q         <= '0;
      prev_tick_q   <= '0;
      have_prev_q   <= 1'b0;
      sum_q         <= '0;
      total_q       <= '0;
      latest_q      <= '0;
      last_pulse_q  <= '0;
      probe_q       <= '0;
      delta_q       <= '0;
      tol_q         <= '0;
      m_q           <= '0;
      e_q           <= '0;
      neg_q         <= 1'b0;
      n_q           <= '0;
      rem_q         <= '0;
      quot_q        <= '0;
      div_cnt_q     <= '0;
      res_status_q  <= '0;
      res_seconds_q <= '0;
      res_ppb_q     <= '0;
      res_last_q    <= '0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
      m_user_q      <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            case (op_e'(s_axis_tuser_i))
              OP_OVERFLOW: begin
                if (cfg.run) begin
                  ovf_q <= ovf_q + OVF_W'(1);
                end
              end
              OP_CAPTURE: begin
                if (cfg.run) begin
                  last_pulse_q <= s_data.now_ms;
                  prev_tick_q  <= tick;
                  if (!have_prev_q) begin
                    have_prev_q <= 1'b1;
                  end else begin
                    latest_q <= tick - prev_tick_q;
                    delta_q  <= tick - prev_tick_q;
                    state_q  <= S_TOL_MUL;
                  end
                end
              end
              OP_STATUS: begin
                res_seconds_q <= '0;
                res_ppb_q     <= '0;
                res_last_q    <= cfg.run ? latest_q : 32'd0;
                state_q       <= S_RESULT;
                if (!cfg.run) begin
                  res_status_q <= ST_IDLE;
                end else begin
                  probe_q <= s_data.counter_now;
                  if (s_data.counter_now == probe_q) begin
                    res_status_q <= ST_NO_CLOCK;
                  end else if (!have_prev_q || (elapsed > 32'(cfg.timeout))) begin
                    res_status_q <= ST_NO_PULSE;
                  end else if (total_q == '0) begin
                    res_status_q <= ST_SETTLING;
                  end else begin
                    res_status_q  <= ST_MEASURING;
                    res_seconds_q <= total_q;
                    state_q       <= S_EXP_MUL;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_TOL_MUL: state_q <= S_TOL_FIX;

        S_TOL_FIX: begin
          tol_q   <= q0 + TOL_W'(tol_rem >= TOL_RESIDUE);
          state_q <= S_WINDOW;
        end

        S_WINDOW: begin
          if (outside) begin
            sum_q   <= '0;
            total_q <= '0;
          end else if (total_q != '1) begin
            sum_q   <= sum_q + 64'(delta_q);
            total_q <= total_q + 32'd1;
          end
          state_q <= S_IDLE;
        end

        S_EXP_MUL: state_q <= S_DIFF;

        S_DIFF: begin
          e_q     <= prod;
          m_q     <= sub_diff[63:0];
          neg_q   <= borrow;
          state_q <= S_NEGATE;
        end

        S_NEGATE: begin
          if (neg_q) begin
            m_q <= sub_diff[63:0];
          end
          state_q <= S_RANGE;
        end

        S_RANGE: begin
          // error of 100% or more is far past the limit
          if (!borrow) begin
            quot_q  <= PPB_LIMIT;
            state_q <= S_SIGN;
          end else begin
            state_q <= S_N_LO;
          end
        end

        S_N_LO: state_q <= S_N_HI;

        S_N_HI: begin
          n_q     <= N_W'(prod[61:0]);
          state_q <= S_N_ADD;
        end

        S_N_ADD: begin
          n_q     <= n_q + {prod[61:0], 32'd0};
          state_q <= S_DIV_INIT;
        end

        S_DIV_INIT: begin
          // m < e keeps the top part below the divisor
          rem_q     <= n_q[N_W-1:SCALE_W];
          quot_q    <= '0;
          div_cnt_q <= CNT_W'(DIV_STEPS - 1);
          state_q   <= S_DIV;
        end

        S_DIV: begin
          rem_q     <= borrow ? div_shift[63:0] : sub_diff[63:0];
          quot_q    <= {quot_q[SCALE_W-2:0], !borrow};
          n_q       <= {n_q[N_W-2:0], 1'b0};
          div_cnt_q <= div_cnt_q - CNT_W'(1);
          if (div_cnt_q == '0) begin
            state_q <= S_SIGN;
          end
        end

        S_SIGN: begin
          res_ppb_q <= neg_q ? (24'd0 - 24'(q_clip)) : 24'(q_clip);
          state_q   <= S_RESULT;
        end

        S_RESULT: begin
          if (out_free) begin
            m_valid_q              <= 1'b1;
            m_user_q               <= res_status_q;
            m_data_q.seconds       <= res_seconds_q;
            m_data_q.error_ppb     <= res_ppb_q;
            m_data_q.last_interval <= res_last_q;
            state_q                <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase

      if (cfg.clear) begin
        ovf_q        <= '0;
        prev_tick_q  <= '0;
        have_prev_q  <= 1'b0;
        sum_q        <= '0;
        total_q      <= '0;
        latest_q     <= '0;
        last_pulse_q <= '0;
        probe_q      <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/pfem_checker.sv
`default_nettype none

module pfem_checker
  import pfem_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid_i,
  input wire logic                   s_axis_tready_o,
  input wire logic [1:0]             s_axis_tuser_i,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic [2:0]             m_axis_tuser_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // a status read keeps the input side closed while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == 2'(OP_STATUS))
      |=> !s_axis_tready_o)
    else $error("input accepted during status read");

  // a new result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result without pending read");

  // seconds and error are only reported while measuring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != 3'(ST_MEASURING)) |-> m_axis_tdata_o[55:0] == '0)
    else $error("measurement fields set outside measuring");

endmodule

bind pps_frequency_error_meter_unit pfem_checker u_pfem_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
